### sv/lgrs_pkg.sv
// ----------------------------------------------------------------------------
// Life row stream package
// Request types, neighbor bundle and the B3/S23 cell rule.
// ----------------------------------------------------------------------------
package lgrs_pkg;

  localparam int unsigned ROW_W  = 64;
  localparam int unsigned QDEPTH = 3;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [ROW_W-1:0] row_cells;
    logic             last_row;
  } lgrs_in_req_t;

  typedef struct packed {
    logic [ROW_W-1:0] next_cells;
    logic             frame_end;
  } lgrs_out_req_t;

  // bits one cell shows to its neighbors
  typedef struct packed {
    logic above;
    logic middle;
    logic row;
  } lgrs_nbr_t;

  localparam lgrs_nbr_t NBR_DEAD = '{above: 1'b0, middle: 1'b0, row: 1'b0};

  // up to two results from one accepted row, first then second
  typedef struct packed {
    logic          first_vld;
    logic          second_vld;
    lgrs_out_req_t first;
    lgrs_out_req_t second;
  } lgrs_push_t;

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] s;
    s = 4'd0;
    for (int i = 0; i < 8; i++) begin
      s = s + {3'd0, v[i]};
    end
    return s;
  endfunction

  function automatic logic life_rule(input logic self, input logic [3:0] n);
    return (n == 4'd3) || ((n == 4'd2) && self);
  endfunction

endpackage

### sv/lgrs_cell.sv
// ----------------------------------------------------------------------------
// Life row stream cell
// Holds one column of the two stored rows and computes both next-state bits.
// ----------------------------------------------------------------------------
module lgrs_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic              clear,
  input  logic              row_bit,
  input  lgrs_pkg::lgrs_nbr_t left_nbr,
  input  lgrs_pkg::lgrs_nbr_t right_nbr,
  output lgrs_pkg::lgrs_nbr_t own_nbr,
  output logic              mid_next,
  output logic              low_next
);
  import lgrs_pkg::*;

  logic above_r, above_nxt;
  logic middle_r, middle_nxt;

  assign own_nbr = '{above: above_r, middle: middle_r, row: row_bit};

  // middle row against row above and new row below
  assign mid_next = life_rule(middle_r, pop8({left_nbr.above, above_r, right_nbr.above,
                                              left_nbr.middle, right_nbr.middle,
                                              left_nbr.row, row_bit, right_nbr.row}));

  // new row as bottom row, dead below
  assign low_next = life_rule(row_bit, pop8({left_nbr.middle, middle_r, right_nbr.middle,
                                             left_nbr.row, right_nbr.row, 3'b000}));

  always_comb begin
    above_nxt  = above_r;
    middle_nxt = middle_r;
    if (advance) begin
      if (clear) begin
        above_nxt  = 1'b0;
        middle_nxt = 1'b0;
      end else begin
        above_nxt  = middle_r;
        middle_nxt = row_bit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      above_r  <= 1'b0;
      middle_r <= 1'b0;
    end else begin
      above_r  <= above_nxt;
      middle_r <= middle_nxt;
    end
  end

endmodule

### sv/lgrs_outq.sv
// ----------------------------------------------------------------------------
// Life row stream result queue
// Three-entry shifting queue that takes up to two results per cycle.
// ----------------------------------------------------------------------------
module lgrs_outq (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lgrs_pkg::lgrs_push_t    push,
  output logic                    full,
  output logic                    out_valid,
  input  logic                    out_stall,
  output lgrs_pkg::lgrs_out_req_t out_req
);
  import lgrs_pkg::*;

  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  lgrs_out_req_t     q_r [QDEPTH];
  lgrs_out_req_t     q_nxt [QDEPTH];
  logic              pop;
  logic [QCNT_W-1:0] base;
  logic [QCNT_W-1:0] n_push;
  lgrs_out_req_t     head_item;

  assign out_valid = (cnt_r != '0);
  assign out_req   = q_r[0];
  assign full      = (cnt_r >= QCNT_W'(2));
  assign pop       = out_valid && !out_stall;
  assign base      = cnt_r - QCNT_W'(pop);
  assign n_push    = QCNT_W'(push.first_vld) + QCNT_W'(push.second_vld);
  assign head_item = push.first_vld ? push.first : push.second;
  assign cnt_nxt   = base + n_push;

  always_comb begin
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && (i < QDEPTH - 1)) begin
        q_nxt[i] = q_r[(i + 1) % QDEPTH];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if ((n_push != '0) && (base == QCNT_W'(i))) begin
        q_nxt[i] = head_item;
      end
      if ((n_push == QCNT_W'(2)) && (QCNT_W'(base + QCNT_W'(1)) == QCNT_W'(i))) begin
        q_nxt[i] = push.second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("result queue count beyond depth");

endmodule

### sv/life_generation_row_stream_unit.sv
// ----------------------------------------------------------------------------
// Life generation row stream unit
// Each result is registered in the queue before out_req; a second follows the first.
// Throughput: one row per cycle; in_stall is high while two or more results wait.
// The row pipeline is a chain of per-column cells; a three-entry queue feeds out_.
// Synchronous active-low reset clears both stored rows, held flag and queue.
// ----------------------------------------------------------------------------
module life_generation_row_stream_unit #(
  parameter int unsigned GRID_COLS = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  lgrs_pkg::lgrs_in_req_t  in_req,
  output logic                    out_valid,
  input  logic                    out_stall,
  output lgrs_pkg::lgrs_out_req_t out_req
);
  import lgrs_pkg::*;

  localparam logic [ROW_W-1:0] COL_MASK = {ROW_W{1'b1}} >> (ROW_W - GRID_COLS);

  logic             accept;
  logic             middle_valid_r, middle_valid_nxt;
  logic             q_full;
  logic [ROW_W-1:0] mid_vec;
  logic [ROW_W-1:0] low_vec;
  lgrs_nbr_t        nbr [GRID_COLS];
  lgrs_push_t       push;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  for (genvar c = 0; c < ROW_W; c++) begin : g_col
    if (c < GRID_COLS) begin : g_cell
      lgrs_nbr_t left_nbr;
      lgrs_nbr_t right_nbr;
      if (c == 0) begin : g_left_edge
        assign left_nbr = NBR_DEAD;
      end else begin : g_left
        assign left_nbr = nbr[c-1];
      end
      if (c == GRID_COLS - 1) begin : g_right_edge
        assign right_nbr = NBR_DEAD;
      end else begin : g_right
        assign right_nbr = nbr[c+1];
      end
      lgrs_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (accept),
        .clear    (in_req.last_row),
        .row_bit  (in_req.row_cells[c]),
        .left_nbr (left_nbr),
        .right_nbr(right_nbr),
        .own_nbr  (nbr[c]),
        .mid_next (mid_vec[c]),
        .low_next (low_vec[c])
      );
    end else begin : g_pad
      assign mid_vec[c] = 1'b0;
      assign low_vec[c] = 1'b0;
    end
  end

  always_comb begin
    middle_valid_nxt = middle_valid_r;
    if (accept) begin
      middle_valid_nxt = !in_req.last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      middle_valid_r <= 1'b0;
    end else begin
      middle_valid_r <= middle_valid_nxt;
    end
  end

  assign push.first_vld  = accept && middle_valid_r;
  assign push.second_vld = accept && in_req.last_row;
  assign push.first      = '{next_cells: mid_vec, frame_end: 1'b0};
  assign push.second     = '{next_cells: low_vec, frame_end: 1'b1};

  lgrs_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (q_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_req  (out_req)
  );

  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req.last_row) |=> !middle_valid_r)
    else $error("held row survived bottom row");

  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_req.last_row) |=> middle_valid_r)
    else $error("row not held after accept");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_req.next_cells & ~COL_MASK) == '0))
    else $error("live cell beyond grid columns");

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// Life generation row stream unit testbench
// Streams frames of packed rows, short and long, sparse and dense, through
// the unit under random idling on both sides. A B3/S23 row predictor tracks
// the two held rows and queues the expected next-generation rows. Each result
// is checked against them in order.
// ----------------------------------------------------------------------------
module tb_top;
  import lgrs_pkg::*;

  localparam int GRID_COLS     = 64;
  localparam int BIRTH_COUNT   = 3;
  localparam int KEEP_COUNT    = 2;
  localparam int IDLE_PCT      = 13;
  localparam int ROW_TARGET    = 1600;
  localparam int HOLD_AT       = 300;
  localparam int HOLD_CYCLES   = 250;
  localparam int WATCHDOG      = 4000;
  localparam int DRAIN_CYCLES  = 20;
  localparam logic [ROW_W-1:0] COL_MASK = {ROW_W{1'b1}} >> (ROW_W - GRID_COLS);

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  lgrs_in_req_t  in_req = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  lgrs_out_req_t out_req;

  lgrs_in_req_t  pending_rows[$];
  lgrs_out_req_t next_rows_due[$];

  logic [ROW_W-1:0] row_above = '0;
  logic [ROW_W-1:0] row_held = '0;
  bit               row_is_held = 1'b0;

  int rows_queued = 0;
  int rows_taken = 0;
  int frames_taken = 0;
  int results_seen = 0;
  int errors = 0;
  int quiet_cycles = 0;
  int stall_cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  life_generation_row_stream_unit #(.GRID_COLS(GRID_COLS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [ROW_W-1:0] life_step_row(input logic [ROW_W-1:0] up,
                                                     input logic [ROW_W-1:0] mid,
                                                     input logic [ROW_W-1:0] down);
    logic [ROW_W-1:0] nxt;
    int n;
    nxt = '0;
    for (int c = 0; c < GRID_COLS; c++) begin
      n = 0;
      for (int d = -1; d <= 1; d++) begin
        if (c + d >= 0 && c + d < GRID_COLS) begin
          n += int'(up[c+d]) + int'(down[c+d]);
          if (d != 0) n += int'(mid[c+d]);
        end
      end
      nxt[c] = (n == BIRTH_COUNT) || (n == KEEP_COUNT && mid[c]);
    end
    return nxt & COL_MASK;
  endfunction

  function automatic lgrs_out_req_t make_next(input logic [ROW_W-1:0] cells,
                                              input logic fe);
    lgrs_out_req_t r;
    r.next_cells = cells;
    r.frame_end  = fe;
    return r;
  endfunction

  task automatic advance_life_rows(input lgrs_in_req_t r);
    logic [ROW_W-1:0] row;
    row = r.row_cells & COL_MASK;
    if (!row_is_held) begin
      if (r.last_row) begin
        next_rows_due.push_back(make_next(life_step_row('0, row, '0), 1'b1));
      end else begin
        row_above   = '0;
        row_held    = row;
        row_is_held = 1'b1;
      end
    end else begin
      next_rows_due.push_back(make_next(life_step_row(row_above, row_held, row), 1'b0));
      if (r.last_row) begin
        next_rows_due.push_back(make_next(life_step_row(row_held, row, '0), 1'b1));
        row_above   = '0;
        row_held    = '0;
        row_is_held = 1'b0;
      end else begin
        row_above = row_held;
        row_held  = row;
      end
    end
  endtask

  task automatic check_next_row(input lgrs_out_req_t got);
    lgrs_out_req_t want;
    results_seen++;
    if (next_rows_due.size() == 0) begin
      $error("unexpected result: next_cells %h frame_end %0b", got.next_cells, got.frame_end);
      errors++;
    end else begin
      want = next_rows_due.pop_front();
      if (got.next_cells !== want.next_cells) begin
        $error("next_cells mismatch: expected %h actual %h", want.next_cells, got.next_cells);
        errors++;
      end
      if (got.frame_end !== want.frame_end) begin
        $error("frame_end mismatch: expected %0b actual %0b", want.frame_end, got.frame_end);
        errors++;
      end
    end
  endtask

  task automatic queue_row(input logic [ROW_W-1:0] cells, input logic last);
    lgrs_in_req_t r;
    r.row_cells = cells;
    r.last_row  = last;
    pending_rows.push_back(r);
    rows_queued++;
  endtask

  function automatic logic [ROW_W-1:0] random_row(input int mode);
    logic [ROW_W-1:0] a, b, c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case (mode)
      0: return a;
      1: return a & b & c;
      2: return a | b;
      3: return a & b;
      default: return 64'(($urandom_range(7) | 32'h2)) << $urandom_range(ROW_W - 1);
    endcase
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_life_rows(in_req);
        rows_taken++;
        if (in_req.last_row) frames_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_rows.size() > 0 &&
            (hold_left > 0 || (rows_taken >= 700 && rows_taken < 1000) ||
             $urandom_range(99) >= IDLE_PCT)) begin
          in_req   <= pending_rows.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) check_next_row(out_req);
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !(results_seen >= 700 && results_seen < 1000) &&
                     ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (in_valid && in_stall) stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG) @(posedge clk);
    $display("timeout: %0d cycles without a handshake", WATCHDOG);
    $display("life_generation_row_stream_unit verification failed");
    $finish;
  end

  initial begin
    int len;
    int mode;
    queue_row({ROW_W{1'b1}}, 1'b1);
    queue_row('0, 1'b1);
    queue_row(64'h7, 1'b1);
    queue_row(64'h2, 1'b0);
    queue_row(64'h2, 1'b0);
    queue_row(64'h2, 1'b1);
    queue_row({ROW_W{1'b1}}, 1'b0);
    queue_row({ROW_W{1'b1}}, 1'b1);
    queue_row(64'h8000_0000_0000_0003, 1'b0);
    queue_row(64'hC000_0000_0000_0001, 1'b0);
    queue_row(64'h8000_0000_0000_0003, 1'b1);
    queue_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    queue_row(64'h5555_5555_5555_5555, 1'b0);
    queue_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    queue_row(64'h5555_5555_5555_5555, 1'b1);
    queue_row('0, 1'b0);
    queue_row({ROW_W{1'b1}}, 1'b0);
    queue_row('0, 1'b1);
    while (rows_queued < ROW_TARGET) begin
      if ($urandom_range(9) < 8) len = $urandom_range(6, 1);
      else len = $urandom_range(24, 7);
      mode = $urandom_range(4);
      for (int i = 0; i < len; i++) begin
        queue_row(random_row($urandom_range(3) == 0 ? $urandom_range(4) : mode),
                  i == len - 1);
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_rows.size() > 0 || in_valid || next_rows_due.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (next_rows_due.size() > 0) begin
      $error("%0d expected next-generation rows never arrived", next_rows_due.size());
      errors++;
    end
    $display("Covered %0d rows in %0d frames, %0d next-generation rows compared,",
             rows_taken, frames_taken, results_seen);
    $display("  %0d cycles of input backpressure, %0d mismatches", stall_cycles, errors);
    if (errors == 0) begin
      $display("life_generation_row_stream_unit verification clean");
    end else begin
      $display("life_generation_row_stream_unit verification failed");
    end
    $finish;
  end

endmodule

### sim.f
sv/lgrs_pkg.sv
sv/lgrs_cell.sv
sv/lgrs_outq.sv
sv/life_generation_row_stream_unit.sv
tb/tb_top.sv
